@@ design/pcva_pkg.sv @@
// Types, register indexes and mode decoding for the pixel channel view adjust block.
// No dependencies; used by pixel_channel_view_adjust_core and the testbench checker.
package pcva_pkg;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } pcva_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pcva_out_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_MODE     = 3'd0;
  localparam logic [2:0] CFG_BG_RED   = 3'd1;
  localparam logic [2:0] CFG_BG_GREEN = 3'd2;
  localparam logic [2:0] CFG_BG_BLUE  = 3'd3;

  localparam logic [4:0] NUM_MODES = 5'd18;

  typedef enum logic [1:0] {
    GRP_PLAIN,
    GRP_INV,
    GRP_RECIP
  } pcva_grp_e;

  typedef enum logic [2:0] {
    BASE_RGBA,
    BASE_RGB,
    BASE_R,
    BASE_G,
    BASE_B,
    BASE_A
  } pcva_base_e;

  typedef struct packed {
    logic       mode_ok;
    pcva_grp_e  grp;
    pcva_base_e base;
  } pcva_ctl_t;

  function automatic pcva_ctl_t decode_mode(input logic [4:0] mode);
    pcva_ctl_t  ctl;
    logic [4:0] rem;
    ctl.mode_ok = (mode < NUM_MODES);
    priority if (mode >= 5'd12) begin
      ctl.grp = GRP_RECIP;
      rem     = mode - 5'd12;
    end else if (mode >= 5'd6) begin
      ctl.grp = GRP_INV;
      rem     = mode - 5'd6;
    end else begin
      ctl.grp = GRP_PLAIN;
      rem     = mode;
    end
    ctl.base = pcva_base_e'(rem[2:0]);
    return ctl;
  endfunction

  function automatic logic [7:0] inv8(input logic [7:0] v);
    return 8'd255 - v;
  endfunction

  // floor(255 / v), with zero mapped to 255
  function automatic logic [7:0] recip8(input logic [7:0] v);
    logic [7:0] q;
    priority if (v >= 8'd128) q = 8'd1;
    else if (v >= 8'd86) q = 8'd2;
    else if (v >= 8'd64) q = 8'd3;
    else if (v >= 8'd52) q = 8'd4;
    else if (v >= 8'd43) q = 8'd5;
    else if (v >= 8'd37) q = 8'd6;
    else if (v >= 8'd32) q = 8'd7;
    else begin
      unique case (v[4:0])
        5'd0:  q = 8'd255;
        5'd1:  q = 8'd255;
        5'd2:  q = 8'd127;
        5'd3:  q = 8'd85;
        5'd4:  q = 8'd63;
        5'd5:  q = 8'd51;
        5'd6:  q = 8'd42;
        5'd7:  q = 8'd36;
        5'd8:  q = 8'd31;
        5'd9:  q = 8'd28;
        5'd10: q = 8'd25;
        5'd11: q = 8'd23;
        5'd12: q = 8'd21;
        5'd13: q = 8'd19;
        5'd14: q = 8'd18;
        5'd15: q = 8'd17;
        5'd16: q = 8'd15;
        5'd17: q = 8'd15;
        5'd18: q = 8'd14;
        5'd19: q = 8'd13;
        5'd20: q = 8'd12;
        5'd21: q = 8'd12;
        5'd22: q = 8'd11;
        5'd23: q = 8'd11;
        5'd24: q = 8'd10;
        5'd25: q = 8'd10;
        5'd26: q = 8'd9;
        5'd27: q = 8'd9;
        5'd28: q = 8'd9;
        5'd29: q = 8'd8;
        5'd30: q = 8'd8;
        5'd31: q = 8'd8;
        default: q = 8'd255;
      endcase
    end
    return q;
  endfunction

endpackage

@@ design/pcva_chan_blend.sv @@
// One colour channel of the alpha blend: registered c*a + bg*(255-a), then floor divide by 255.
// Depends on nothing but plain logic; instantiated three times by the core.
module pcva_chan_blend (
  input  logic       clk_i,
  input  logic [7:0] chan_i,
  input  logic [7:0] alpha_i,
  input  logic [7:0] bg_i,
  output logic [7:0] blend_o
);

  logic [16:0] sum_full;
  logic [15:0] sum_d;
  logic [15:0] sum_q;
  logic [15:0] div_tmp;

  // Weights add up to 255, so the sum never exceeds 255*255 and fits 16 bits
  assign sum_full = 17'(chan_i * alpha_i) + 17'(bg_i * (8'd255 - alpha_i));
  assign sum_d    = sum_full[15:0];

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  // Exact floor(x / 255) for x up to 255*255, the largest sum; larger x would overflow div_tmp
  assign div_tmp = sum_q + {8'd0, sum_q[15:8]} + 16'd1;
  assign blend_o = div_tmp[15:8];

endmodule

@@ design/pixel_channel_view_adjust_core.sv @@
// Top level of the pixel channel view adjust block: pre-step, blend and channel select.
// Depends on pcva_pkg and pcva_chan_blend.
//
// One pixel request is taken per clock, every clock: busy stays low and the result
// appears on pix_o with out_valid_o high once start has passed the register stages,
// for one cycle only, since the receiver cannot stall. The three register stages are
// the one-minus / reciprocal table, the per-channel blend multipliers, and the divide
// by 255 with the final channel select. Configuration writes are always accepted
// (cfg_ready_o high) and must only be issued while no pixel is in flight.
module pixel_channel_view_adjust_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pcva_pkg::pcva_in_t pix_i,
  output logic               out_valid_o,
  output pcva_pkg::pcva_out_t pix_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  logic [4:0] mode_q;
  logic [7:0] bg_red_q;
  logic [7:0] bg_green_q;
  logic [7:0] bg_blue_q;

  logic                valid_s1_q;
  logic                valid_s2_q;
  logic                out_valid_q;
  pcva_pkg::pcva_in_t  pre_d;
  pcva_pkg::pcva_in_t  pix_s1_q;
  pcva_pkg::pcva_in_t  pix_s2_q;
  pcva_pkg::pcva_ctl_t ctl_d;
  pcva_pkg::pcva_ctl_t ctl_s1_q;
  pcva_pkg::pcva_ctl_t ctl_s2_q;
  pcva_pkg::pcva_out_t res_d;
  pcva_pkg::pcva_out_t res_q;
  logic [7:0]          blend_red;
  logic [7:0]          blend_green;
  logic [7:0]          blend_blue;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 5'd0;
      bg_red_q   <= 8'd0;
      bg_green_q <= 8'd0;
      bg_blue_q  <= 8'd0;
    end else if (cfg_valid_i) begin
      // Drop writes to indexes beyond the register list
      unique case (cfg_index_i)
        pcva_pkg::CFG_MODE:     mode_q     <= cfg_data_i[4:0];
        pcva_pkg::CFG_BG_RED:   bg_red_q   <= cfg_data_i;
        pcva_pkg::CFG_BG_GREEN: bg_green_q <= cfg_data_i;
        pcva_pkg::CFG_BG_BLUE:  bg_blue_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: decode the mode and apply the one-minus or reciprocal pre-step
  always_comb begin
    ctl_d = pcva_pkg::decode_mode(mode_q);
    pre_d = pix_i;
    if (ctl_d.mode_ok) begin
      unique case (ctl_d.grp)
        pcva_pkg::GRP_INV: begin
          unique case (ctl_d.base)
            pcva_pkg::BASE_RGBA, pcva_pkg::BASE_RGB: begin
              pre_d.in_red   = pcva_pkg::inv8(pix_i.in_red);
              pre_d.in_green = pcva_pkg::inv8(pix_i.in_green);
              pre_d.in_blue  = pcva_pkg::inv8(pix_i.in_blue);
              pre_d.in_alpha = pcva_pkg::inv8(pix_i.in_alpha);
            end
            pcva_pkg::BASE_R: pre_d.in_red   = pcva_pkg::inv8(pix_i.in_red);
            pcva_pkg::BASE_G: pre_d.in_green = pcva_pkg::inv8(pix_i.in_green);
            pcva_pkg::BASE_B: pre_d.in_blue  = pcva_pkg::inv8(pix_i.in_blue);
            default:          pre_d.in_alpha = pcva_pkg::inv8(pix_i.in_alpha);
          endcase
        end
        pcva_pkg::GRP_RECIP: begin
          unique case (ctl_d.base)
            pcva_pkg::BASE_RGBA: begin
              pre_d.in_red   = pcva_pkg::recip8(pix_i.in_red);
              pre_d.in_green = pcva_pkg::recip8(pix_i.in_green);
              pre_d.in_blue  = pcva_pkg::recip8(pix_i.in_blue);
              pre_d.in_alpha = pcva_pkg::recip8(pix_i.in_alpha);
            end
            pcva_pkg::BASE_RGB: begin
              pre_d.in_red   = pcva_pkg::recip8(pix_i.in_red);
              pre_d.in_green = pcva_pkg::recip8(pix_i.in_green);
              pre_d.in_blue  = pcva_pkg::recip8(pix_i.in_blue);
            end
            pcva_pkg::BASE_R: pre_d.in_red   = pcva_pkg::recip8(pix_i.in_red);
            pcva_pkg::BASE_G: pre_d.in_green = pcva_pkg::recip8(pix_i.in_green);
            pcva_pkg::BASE_B: pre_d.in_blue  = pcva_pkg::recip8(pix_i.in_blue);
            default:          pre_d.in_alpha = pcva_pkg::recip8(pix_i.in_alpha);
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_s1_q  <= 1'b0;
      valid_s2_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid_s1_q  <= start;
      valid_s2_q  <= valid_s1_q;
      out_valid_q <= valid_s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_s1_q <= pre_d;
    ctl_s1_q <= ctl_d;
    pix_s2_q <= pix_s1_q;
    ctl_s2_q <= ctl_s1_q;
    res_q    <= res_d;
  end

  // Stage 2: blend products, registered inside each channel unit
  pcva_chan_blend u_blend_red (
    .clk_i   (clk_i),
    .chan_i  (pix_s1_q.in_red),
    .alpha_i (pix_s1_q.in_alpha),
    .bg_i    (bg_red_q),
    .blend_o (blend_red)
  );

  pcva_chan_blend u_blend_green (
    .clk_i   (clk_i),
    .chan_i  (pix_s1_q.in_green),
    .alpha_i (pix_s1_q.in_alpha),
    .bg_i    (bg_green_q),
    .blend_o (blend_green)
  );

  pcva_chan_blend u_blend_blue (
    .clk_i   (clk_i),
    .chan_i  (pix_s1_q.in_blue),
    .alpha_i (pix_s1_q.in_alpha),
    .bg_i    (bg_blue_q),
    .blend_o (blend_blue)
  );

  // Stage 3: divide by 255 and pick the view; an unknown mode passes the pixel through
  always_comb begin
    res_d.out_red   = pix_s2_q.in_red;
    res_d.out_green = pix_s2_q.in_green;
    res_d.out_blue  = pix_s2_q.in_blue;
    res_d.out_alpha = pix_s2_q.in_alpha;
    if (ctl_s2_q.mode_ok) begin
      res_d.out_alpha = 8'd255;
      unique case (ctl_s2_q.base)
        pcva_pkg::BASE_RGBA: begin
          res_d.out_red   = blend_red;
          res_d.out_green = blend_green;
          res_d.out_blue  = blend_blue;
        end
        pcva_pkg::BASE_RGB: ;
        pcva_pkg::BASE_R: begin
          res_d.out_green = pix_s2_q.in_red;
          res_d.out_blue  = pix_s2_q.in_red;
        end
        pcva_pkg::BASE_G: begin
          res_d.out_red   = pix_s2_q.in_green;
          res_d.out_blue  = pix_s2_q.in_green;
        end
        pcva_pkg::BASE_B: begin
          res_d.out_red   = pix_s2_q.in_blue;
          res_d.out_green = pix_s2_q.in_blue;
        end
        default: begin
          res_d.out_red   = pix_s2_q.in_alpha;
          res_d.out_green = pix_s2_q.in_alpha;
          res_d.out_blue  = pix_s2_q.in_alpha;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign pix_o       = res_q;

endmodule

@@ tb/sv/pcva_view_checker.sv @@
`timescale 1ns / 1ps
// Checker for the pixel channel view adjust block: it tracks the register writes and
// predicts each adjusted pixel, then compares it with the block's output.
// Depends on pcva_pkg.
module pcva_view_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  pcva_pkg::pcva_in_t  pix_i,
  input  logic                out_valid_i,
  input  pcva_pkg::pcva_out_t pix_out_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  output int                  mismatch_cnt_o,
  output int                  pending_cnt_o
);

  logic [4:0] view_mode;
  logic [7:0] bg_red;
  logic [7:0] bg_green;
  logic [7:0] bg_blue;

  pcva_pkg::pcva_out_t pending_pixels[$];

  function automatic logic [7:0] one_over(input logic [7:0] v);
    if (v == 8'd0) begin
      return 8'd255;
    end
    return 8'(255 / int'(v));
  endfunction

  // floor((c*a + bg*(255-a)) / 255)
  function automatic logic [7:0] over_bg(input logic [7:0] c, input logic [7:0] a,
                                         input logic [7:0] bg);
    int mix;
    mix = int'(c) * int'(a) + int'(bg) * (255 - int'(a));
    return 8'(mix / 255);
  endfunction

  function automatic pcva_pkg::pcva_out_t adjusted_pixel(input pcva_pkg::pcva_in_t px);
    pcva_pkg::pcva_grp_e  grp;
    pcva_pkg::pcva_base_e base;
    pcva_pkg::pcva_out_t  res;
    logic [7:0]           r;
    logic [7:0]           g;
    logic [7:0]           b;
    logic [7:0]           a;
    r = px.in_red;
    g = px.in_green;
    b = px.in_blue;
    a = px.in_alpha;
    if (view_mode < pcva_pkg::NUM_MODES) begin
      grp  = pcva_pkg::pcva_grp_e'(2'(view_mode / 5'd6));
      base = pcva_pkg::pcva_base_e'(3'(view_mode % 5'd6));
      case (grp)
        pcva_pkg::GRP_INV: begin
          case (base)
            pcva_pkg::BASE_RGBA, pcva_pkg::BASE_RGB: begin
              r = 8'd255 - r;
              g = 8'd255 - g;
              b = 8'd255 - b;
              a = 8'd255 - a;
            end
            pcva_pkg::BASE_R: r = 8'd255 - r;
            pcva_pkg::BASE_G: g = 8'd255 - g;
            pcva_pkg::BASE_B: b = 8'd255 - b;
            default:          a = 8'd255 - a;
          endcase
        end
        pcva_pkg::GRP_RECIP: begin
          case (base)
            pcva_pkg::BASE_RGBA: begin
              r = one_over(r);
              g = one_over(g);
              b = one_over(b);
              a = one_over(a);
            end
            // alpha is left alone here, it is forced to 255 anyway
            pcva_pkg::BASE_RGB: begin
              r = one_over(r);
              g = one_over(g);
              b = one_over(b);
            end
            pcva_pkg::BASE_R: r = one_over(r);
            pcva_pkg::BASE_G: g = one_over(g);
            pcva_pkg::BASE_B: b = one_over(b);
            default:          a = one_over(a);
          endcase
        end
        default: ;
      endcase
      case (base)
        pcva_pkg::BASE_RGBA: begin
          r = over_bg(r, a, bg_red);
          g = over_bg(g, a, bg_green);
          b = over_bg(b, a, bg_blue);
        end
        pcva_pkg::BASE_RGB: ;
        pcva_pkg::BASE_R: begin
          g = r;
          b = r;
        end
        pcva_pkg::BASE_G: begin
          r = g;
          b = g;
        end
        pcva_pkg::BASE_B: begin
          r = b;
          g = b;
        end
        default: begin
          r = a;
          g = a;
          b = a;
        end
      endcase
      a = 8'd255;
    end
    res.out_red   = r;
    res.out_green = g;
    res.out_blue  = b;
    res.out_alpha = a;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pcva_pkg::pcva_out_t want;
    if (!rst_ni) begin
      view_mode = '0;
      bg_red    = '0;
      bg_green  = '0;
      bg_blue   = '0;
      pending_pixels.delete();
      mismatch_cnt_o = 0;
    end else begin
      if (start_i && !busy_i) begin
        pending_pixels.push_back(adjusted_pixel(pix_i));
      end
      if (out_valid_i) begin
        if (pending_pixels.size() == 0) begin
          $error("pixel out with no request waiting: %h", pix_out_i);
          mismatch_cnt_o++;
        end else begin
          want = pending_pixels.pop_front();
          if (pix_out_i.out_red !== want.out_red) begin
            $error("out_red: expected %0d, got %0d", want.out_red, pix_out_i.out_red);
            mismatch_cnt_o++;
          end
          if (pix_out_i.out_green !== want.out_green) begin
            $error("out_green: expected %0d, got %0d", want.out_green, pix_out_i.out_green);
            mismatch_cnt_o++;
          end
          if (pix_out_i.out_blue !== want.out_blue) begin
            $error("out_blue: expected %0d, got %0d", want.out_blue, pix_out_i.out_blue);
            mismatch_cnt_o++;
          end
          if (pix_out_i.out_alpha !== want.out_alpha) begin
            $error("out_alpha: expected %0d, got %0d", want.out_alpha, pix_out_i.out_alpha);
            mismatch_cnt_o++;
          end
        end
      end
      // the user must write registers only while idle (the block does not enforce it), so apply them after predicting
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          pcva_pkg::CFG_MODE:     view_mode = cfg_data_i[4:0];
          pcva_pkg::CFG_BG_RED:   bg_red    = cfg_data_i;
          pcva_pkg::CFG_BG_GREEN: bg_green  = cfg_data_i;
          pcva_pkg::CFG_BG_BLUE:  bg_blue   = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_cnt_o = pending_pixels.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the pixel channel view adjust testbench: clock, reset, register writes and
// pixel requests. Depends on pcva_pkg, pixel_channel_view_adjust_core and pcva_view_checker.
module tb_top;

  localparam logic [2:0] CFG_FIRST_UNUSED = 3'd4;
  localparam int         PIXEL_TARGET     = 700;
  localparam int         SETTLE_CYCLES    = 4;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  pcva_pkg::pcva_in_t  pix_i;
  logic                out_valid_o;
  pcva_pkg::pcva_out_t pix_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i;
  logic [7:0]          cfg_data_i;
  int                  mismatch_cnt;
  int                  pending_cnt;

  pixel_channel_view_adjust_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pix_i       (pix_i),
    .out_valid_o (out_valid_o),
    .pix_o       (pix_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  pcva_view_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .pix_i          (pix_i),
    .out_valid_i    (out_valid_o),
    .pix_out_i      (pix_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Leaves valid high; the caller drops it once the last write has gone.
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_pixel(input pcva_pkg::pcva_in_t px);
    start <= 1'b1;
    pix_i <= px;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic drain();
    wait (pending_cnt == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pcva_pkg::pcva_in_t random_pixel();
    pcva_pkg::pcva_in_t px;
    px.in_red   = pick_channel();
    px.in_green = pick_channel();
    px.in_blue  = pick_channel();
    px.in_alpha = pick_channel();
    return px;
  endfunction

  // Bursts of back-to-back requests with random gaps; start is low on return.
  task automatic stream_pixels(input int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      if (burst > left) begin
        burst = left;
      end
      repeat (burst) send_pixel(random_pixel());
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    start <= 1'b0;
  endtask

  initial begin : stimulus
    pcva_pkg::pcva_in_t px;
    logic [4:0]         mode;
    int                 sent;
    int                 phase;
    int                 count;
    rst_ni      = 1'b0;
    start       = 1'b0;
    pix_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = pcva_pkg::CFG_MODE;
    cfg_data_i  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // compositing at the alpha extremes and at alpha 128
    write_reg(pcva_pkg::CFG_BG_RED, 8'd255);
    write_reg(pcva_pkg::CFG_BG_GREEN, 8'd0);
    write_reg(pcva_pkg::CFG_BG_BLUE, 8'd128);
    cfg_valid_i <= 1'b0;
    send_pixel('{in_red: 8'd255, in_green: 8'd255, in_blue: 8'd255, in_alpha: 8'd0});
    send_pixel('{in_red: 8'd0, in_green: 8'd0, in_blue: 8'd0, in_alpha: 8'd255});
    send_pixel('{in_red: 8'd12, in_green: 8'd200, in_blue: 8'd77, in_alpha: 8'd128});
    start <= 1'b0;

    // one pixel per mode, plus two modes without meaning; zero and one hit the reciprocal
    for (int m = 0; m < 20; m++) begin
      mode = (m < 19) ? 5'(m) : 5'd31;
      drain();
      write_reg(pcva_pkg::CFG_MODE, {3'b000, mode});
      cfg_valid_i <= 1'b0;
      px.in_red   = 8'd0;
      px.in_green = 8'd1;
      px.in_blue  = 8'd255;
      px.in_alpha = (m % 3 == 0) ? 8'd0 : ((m % 3 == 1) ? 8'd1 : 8'd255);
      send_pixel(px);
      start <= 1'b0;
    end

    // writes past the register list must change nothing
    drain();
    write_reg(pcva_pkg::CFG_MODE, 8'd12);
    for (int k = CFG_FIRST_UNUSED; k < 8; k++) begin
      write_reg(3'(k), 8'hFF);
    end
    cfg_valid_i <= 1'b0;
    send_pixel('{in_red: 8'd3, in_green: 8'd0, in_blue: 8'd200, in_alpha: 8'd0});
    start <= 1'b0;

    sent  = 0;
    phase = 0;
    while (sent < PIXEL_TARGET) begin
      drain();
      case (phase)
        0: begin
          write_reg(pcva_pkg::CFG_MODE, 8'd0);
          write_reg(pcva_pkg::CFG_BG_RED, 8'd0);
          write_reg(pcva_pkg::CFG_BG_GREEN, 8'd0);
          write_reg(pcva_pkg::CFG_BG_BLUE, 8'd0);
        end
        1: begin
          write_reg(pcva_pkg::CFG_MODE, {3'b111, 5'd17});
          write_reg(pcva_pkg::CFG_BG_RED, 8'd255);
          write_reg(pcva_pkg::CFG_BG_GREEN, 8'd255);
          write_reg(pcva_pkg::CFG_BG_BLUE, 8'd255);
        end
        2: write_reg(pcva_pkg::CFG_MODE, 8'd0);
        3: write_reg(pcva_pkg::CFG_MODE, 8'd6);
        4: write_reg(pcva_pkg::CFG_MODE, 8'd12);
        default: begin
          mode = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(18, 31))
                                             : 5'($urandom_range(0, 17));
          write_reg(pcva_pkg::CFG_MODE, {3'($urandom), mode});
          if ($urandom_range(0, 1) == 0) write_reg(pcva_pkg::CFG_BG_RED, pick_channel());
          if ($urandom_range(0, 1) == 0) write_reg(pcva_pkg::CFG_BG_GREEN, pick_channel());
          if ($urandom_range(0, 1) == 0) write_reg(pcva_pkg::CFG_BG_BLUE, pick_channel());
          if ($urandom_range(0, 3) == 0) begin
            write_reg(3'($urandom_range(CFG_FIRST_UNUSED, 7)), 8'($urandom));
          end
        end
      endcase
      cfg_valid_i <= 1'b0;
      count = $urandom_range(10, 50);
      stream_pixels(count);
      sent  += count;
      phase++;
    end

    drain();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
